// ===== design/line_box_intersection_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the line/box intersection core
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LINE_BOX_INTERSECTION_CORE_MACROS_SVH
`define LINE_BOX_INTERSECTION_CORE_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define LBI_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("line box core: implication check failed");
// condition must never hold
`define LBI_ASSERT_NEVER(lbl, clk_s, rst_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(cond)) \
    else $error("line box core: forbidden condition seen");
`else
`define LBI_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define LBI_ASSERT_NEVER(lbl, clk_s, rst_s, cond)
`endif
`endif

// ===== design/lbi_pkg.sv =====
// ----------------------------------------------------------------------------
// Line/box intersection package
// Shared types, pipeline depths and register codes.
// ----------------------------------------------------------------------------
`default_nettype none
package lbi_pkg;

  // divider: two quotient bits per stage, 32 quotient bits
  localparam int QBITS           = 32;
  localparam int STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES      = QBITS / STEPS_PER_STAGE;
  localparam int DIV_LAT         = DIV_STAGES + 2;
  localparam int FACE_LAT        = 2;
  localparam int SEG_LAT         = 7;
  localparam int POST_LAT        = DIV_LAT + FACE_LAT + SEG_LAT;
  localparam int PIPE_LAT        = POST_LAT + 1;

  localparam int NUM_FACES = 6;
  localparam int FACE_IDX_W = 3;
  localparam int ADDR_W = 5;

  typedef logic signed [31:0] q_t;

  localparam q_t Q_MAX = 32'sh7FFF_FFFF;
  localparam q_t Q_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } line_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] seg_start_x;
    logic signed [31:0] seg_start_y;
    logic signed [31:0] seg_start_z;
    logic signed [31:0] seg_end_x;
    logic signed [31:0] seg_end_y;
    logic signed [31:0] seg_end_z;
  } seg_t;

  // one face crossing: hit flag and crossing point
  typedef struct packed {
    logic hit;
    q_t   x;
    q_t   y;
    q_t   z;
  } hit_pt_t;

endpackage
`default_nettype wire

// ===== design/lbi_div_lane.sv =====
// ----------------------------------------------------------------------------
// Pipelined saturating divider lane
// Computes sat32((num * 2^16) / den), truncated toward zero, two bits a stage.
// ----------------------------------------------------------------------------
`default_nettype none
module lbi_div_lane (
  input  logic               clk,
  input  logic signed [32:0] num,
  input  lbi_pkg::q_t        den,
  output lbi_pkg::q_t        quot
);

  logic [32:0] num_abs;
  logic [31:0] den_abs;
  logic [48:0] num_mag;

  logic [31:0] rem_q [lbi_pkg::DIV_STAGES+1];
  logic [31:0] nbits [lbi_pkg::DIV_STAGES+1];
  logic [31:0] quo   [lbi_pkg::DIV_STAGES+1];
  logic [31:0] dm    [lbi_pkg::DIV_STAGES+1];
  logic        neg   [lbi_pkg::DIV_STAGES+1];
  logic        ovf   [lbi_pkg::DIV_STAGES+1];

  lbi_pkg::q_t sat_w;

  // take magnitudes, flag quotients that cannot fit 32 bits
  always_comb begin
    num_abs = num[32] ? 33'(-num) : 33'(num);
    den_abs = den[31] ? 32'(-den) : 32'(den);
    num_mag = {num_abs, 16'h0000};
  end

  always_ff @(posedge clk) begin
    rem_q[0] <= 32'(num_mag[48:32]);
    nbits[0] <= num_mag[31:0];
    quo[0]   <= '0;
    dm[0]    <= den_abs;
    neg[0]   <= num[32] ^ den[31];
    ovf[0]   <= (32'(num_mag[48:32]) >= den_abs);
  end

  // restoring division stages
  for (genvar gs = 0; gs < lbi_pkg::DIV_STAGES; gs++) begin : g_stage
    logic [31:0] r_w;
    logic [31:0] n_w;
    logic [31:0] q_w;
    logic [32:0] trial;

    always_comb begin
      r_w   = rem_q[gs];
      n_w   = nbits[gs];
      q_w   = quo[gs];
      trial = '0;
      for (int k = 0; k < lbi_pkg::STEPS_PER_STAGE; k++) begin
        trial = {r_w, n_w[31]};
        n_w   = {n_w[30:0], 1'b0};
        if (trial >= {1'b0, dm[gs]}) begin
          r_w = 32'(trial - {1'b0, dm[gs]});
          q_w = {q_w[30:0], 1'b1};
        end else begin
          r_w = trial[31:0];
          q_w = {q_w[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      rem_q[gs+1] <= r_w;
      nbits[gs+1] <= n_w;
      quo[gs+1]   <= q_w;
      dm[gs+1]    <= dm[gs];
      neg[gs+1]   <= neg[gs];
      ovf[gs+1]   <= ovf[gs];
    end
  end

  // apply sign and saturate
  always_comb begin
    if (ovf[lbi_pkg::DIV_STAGES]) begin
      sat_w = neg[lbi_pkg::DIV_STAGES] ? lbi_pkg::Q_MIN : lbi_pkg::Q_MAX;
    end else if (!neg[lbi_pkg::DIV_STAGES]) begin
      sat_w = quo[lbi_pkg::DIV_STAGES][31] ? lbi_pkg::Q_MAX : quo[lbi_pkg::DIV_STAGES];
    end else if (quo[lbi_pkg::DIV_STAGES] > 32'h8000_0000) begin
      sat_w = lbi_pkg::Q_MIN;
    end else begin
      sat_w = 32'(-quo[lbi_pkg::DIV_STAGES]);
    end
  end

  always_ff @(posedge clk) begin
    quot <= sat_w;
  end

endmodule
`default_nettype wire

// ===== design/lbi_face.sv =====
// ----------------------------------------------------------------------------
// Face crossing test
// Projects t onto the two other axes, checks the closed box ranges and
// forms the crossing point. Two register stages.
// ----------------------------------------------------------------------------
`default_nettype none
module lbi_face (
  input  logic        clk,
  input  lbi_pkg::q_t t,
  input  logic        dnz,
  input  lbi_pkg::q_t d_u,
  input  lbi_pkg::q_t d_v,
  input  lbi_pkg::q_t o_u,
  input  lbi_pkg::q_t o_v,
  input  lbi_pkg::q_t lo_u,
  input  lbi_pkg::q_t hi_u,
  input  lbi_pkg::q_t lo_v,
  input  lbi_pkg::q_t hi_v,
  input  lbi_pkg::q_t corner,
  output logic        hit,
  output lbi_pkg::q_t p_u,
  output lbi_pkg::q_t p_v,
  output lbi_pkg::q_t p_w
);

  logic signed [63:0] prod_u, prod_v;
  logic               dnz1;
  lbi_pkg::q_t        o_u1, o_v1, corner1;
  logic signed [47:0] off_u, off_v;
  logic               in_u, in_v;

  // (p) / 2^16 truncated toward zero
  function automatic logic signed [47:0] qtrunc(input logic signed [63:0] p);
    logic signed [63:0] b;
    b = p + (p[63] ? 64'sd65535 : 64'sd0);
    return 48'(b >>> 16);
  endfunction

  function automatic logic in_range(input logic signed [47:0] off,
                                    input lbi_pkg::q_t lo, input lbi_pkg::q_t hi,
                                    input lbi_pkg::q_t o);
    logic signed [32:0] fc;
    logic signed [32:0] lc;
    fc = 33'(lo) - 33'(o);
    lc = 33'(hi) - 33'(o);
    return (off >= 48'(fc)) && (off <= 48'(lc));
  endfunction

  // multiply offsets along the other axes
  always_ff @(posedge clk) begin
    prod_u  <= t * d_u;
    prod_v  <= t * d_v;
    dnz1    <= dnz;
    o_u1    <= o_u;
    o_v1    <= o_v;
    corner1 <= corner;
  end

  always_comb begin
    off_u = qtrunc(prod_u);
    off_v = qtrunc(prod_v);
    in_u  = in_range(off_u, lo_u, hi_u, o_u1);
    in_v  = in_range(off_v, lo_v, hi_v, o_v1);
  end

  // range check and crossing point
  always_ff @(posedge clk) begin
    hit <= dnz1 & in_u & in_v;
    p_u <= o_u1 + off_u[31:0];
    p_v <= o_v1 + off_v[31:0];
    p_w <= corner1;
  end

endmodule
`default_nettype wire

// ===== design/lbi_seg.sv =====
// ----------------------------------------------------------------------------
// Segment selection
// Picks the first crossing as start and the farthest later crossing as end
// (earliest on ties). Seven register stages.
// ----------------------------------------------------------------------------
`default_nettype none
module lbi_seg (
  input  logic                                         clk,
  input  lbi_pkg::hit_pt_t [lbi_pkg::NUM_FACES-1:0]    pts,
  output lbi_pkg::seg_t                                result
);

  typedef struct packed {
    logic                              v;
    logic [65:0]                       dsq;
    logic [lbi_pkg::FACE_IDX_W-1:0]    idx;
  } cand_t;

  lbi_pkg::hit_pt_t [lbi_pkg::NUM_FACES-1:0] pts_d [1:6];
  lbi_pkg::hit_pt_t                          s_d   [1:6];
  logic                                      has_d [1:6];

  logic [lbi_pkg::FACE_IDX_W-1:0] first;
  logic                           found;
  logic [2:0]                     cnt;

  logic [lbi_pkg::NUM_FACES-1:0] cand1;
  logic [lbi_pkg::NUM_FACES-1:0] cand2;
  logic [lbi_pkg::NUM_FACES-1:0] cand3;
  logic [63:0] sq2 [lbi_pkg::NUM_FACES][3];
  logic [65:0] dist3 [lbi_pkg::NUM_FACES];
  cand_t       c4 [3];
  cand_t       c5a, c5b;
  cand_t       c6;

  function automatic logic [63:0] sqdiff(input lbi_pkg::q_t a, input lbi_pkg::q_t b);
    logic signed [32:0] df;
    logic [31:0]        m;
    df = 33'(a) - 33'(b);
    m  = df[32] ? 32'(-df) : df[31:0];
    return 64'(m) * 64'(m);
  endfunction

  // keep a unless b is valid and either a is not valid or b is strictly farther
  function automatic cand_t pick(input cand_t a, input cand_t b);
    return (b.v && (!a.v || (b.dsq > a.dsq))) ? b : a;
  endfunction

  // find the first crossing and count crossings
  always_comb begin
    first = '0;
    found = 1'b0;
    cnt   = '0;
    for (int i = 0; i < lbi_pkg::NUM_FACES; i++) begin
      if (pts[i].hit) begin
        if (!found) begin
          first = lbi_pkg::FACE_IDX_W'(i);
          found = 1'b1;
        end
        cnt = cnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pts_d[1] <= pts;
    s_d[1]   <= pts[first];
    has_d[1] <= (cnt >= 3'd2);
    for (int i = 0; i < lbi_pkg::NUM_FACES; i++) begin
      cand1[i] <= pts[i].hit && (lbi_pkg::FACE_IDX_W'(i) != first);
    end
  end

  // carry points and start down the stages
  always_ff @(posedge clk) begin
    for (int k = 2; k <= 6; k++) begin
      pts_d[k] <= pts_d[k-1];
      s_d[k]   <= s_d[k-1];
      has_d[k] <= has_d[k-1];
    end
  end

  // squared coordinate distances from the start
  always_ff @(posedge clk) begin
    cand2 <= cand1;
    for (int i = 0; i < lbi_pkg::NUM_FACES; i++) begin
      sq2[i][0] <= sqdiff(s_d[1].x, pts_d[1][i].x);
      sq2[i][1] <= sqdiff(s_d[1].y, pts_d[1][i].y);
      sq2[i][2] <= sqdiff(s_d[1].z, pts_d[1][i].z);
    end
  end

  // sum to full squared distance
  always_ff @(posedge clk) begin
    cand3 <= cand2;
    for (int i = 0; i < lbi_pkg::NUM_FACES; i++) begin
      dist3[i] <= 66'(sq2[i][0]) + 66'(sq2[i][1]) + 66'(sq2[i][2]);
    end
  end

  // pairwise farthest
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      c4[j] <= pick('{v: cand3[2*j], dsq: dist3[2*j],
                      idx: lbi_pkg::FACE_IDX_W'(2*j)},
                    '{v: cand3[2*j+1], dsq: dist3[2*j+1],
                      idx: lbi_pkg::FACE_IDX_W'(2*j+1)});
    end
  end

  always_ff @(posedge clk) begin
    c5a <= pick(c4[0], c4[1]);
    c5b <= c4[2];
  end

  always_ff @(posedge clk) begin
    c6 <= pick(c5a, c5b);
  end

  // drive the result, zero when fewer than two crossings
  always_ff @(posedge clk) begin
    if (has_d[6]) begin
      result.hit         <= 1'b1;
      result.seg_start_x <= s_d[6].x;
      result.seg_start_y <= s_d[6].y;
      result.seg_start_z <= s_d[6].z;
      result.seg_end_x   <= pts_d[6][c6.idx].x;
      result.seg_end_y   <= pts_d[6][c6.idx].y;
      result.seg_end_z   <= pts_d[6][c6.idx].z;
    end else begin
      result <= '0;
    end
  end

endmodule
`default_nettype wire

// ===== design/line_box_intersection_core.sv =====
// ----------------------------------------------------------------------------
// Line/box intersection core
// Intersects a Q16.16 line with a configured axis-aligned box.
// ----------------------------------------------------------------------------
// One item enters per clock cycle; busy stays low. The result for an item
// is on result with done high for one cycle, in input order. The depth is
// one capture register, the six divider lanes (16 stages of two quotient
// bits plus an input and an output register), the face range checks and
// the segment selection. The receiver cannot stall, so results must be
// taken in the cycle they appear.
// Box registers may be written only while no item is in flight.
`default_nettype none
`include "line_box_intersection_core_macros.svh"
module line_box_intersection_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  lbi_pkg::line_t                item,
  output logic                          done,
  output lbi_pkg::seg_t                 result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lbi_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  lbi_pkg::q_t box_lo [3];
  lbi_pkg::q_t box_hi [3];
  lbi_pkg::reg_idx_t ridx;

  logic                   v0;
  lbi_pkg::line_t         in0;
  lbi_pkg::line_t         dly [lbi_pkg::DIV_LAT];
  logic [lbi_pkg::POST_LAT-1:0] vpipe;

  lbi_pkg::q_t o0 [3];
  lbi_pkg::q_t oa [3];
  lbi_pkg::q_t da [3];

  lbi_pkg::hit_pt_t [lbi_pkg::NUM_FACES-1:0] pts;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign ridx   = lbi_pkg::reg_idx_t'(paddr[lbi_pkg::ADDR_W-1:2]);

  // box register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        box_lo[k] <= '0;
        box_hi[k] <= '0;
      end
    end else if (psel && penable && pwrite && pready) begin
      unique case (ridx)
        lbi_pkg::REG_MIN_X: box_lo[0] <= pwdata;
        lbi_pkg::REG_MIN_Y: box_lo[1] <= pwdata;
        lbi_pkg::REG_MIN_Z: box_lo[2] <= pwdata;
        lbi_pkg::REG_MAX_X: box_hi[0] <= pwdata;
        lbi_pkg::REG_MAX_Y: box_hi[1] <= pwdata;
        lbi_pkg::REG_MAX_Z: box_hi[2] <= pwdata;
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (ridx)
      lbi_pkg::REG_MIN_X: prdata = box_lo[0];
      lbi_pkg::REG_MIN_Y: prdata = box_lo[1];
      lbi_pkg::REG_MIN_Z: prdata = box_lo[2];
      lbi_pkg::REG_MAX_X: prdata = box_hi[0];
      lbi_pkg::REG_MAX_Y: prdata = box_hi[1];
      lbi_pkg::REG_MAX_Z: prdata = box_hi[2];
      default:            prdata = '0;
    endcase
  end

  // capture the incoming item
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in0 <= item;
  end

  // advance valid bits alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[lbi_pkg::POST_LAT-2:0], v0};
    end
  end

  assign done = vpipe[lbi_pkg::POST_LAT-1];

  // hold the line while the dividers run
  always_ff @(posedge clk) begin
    dly[0] <= in0;
    for (int k = 1; k < lbi_pkg::DIV_LAT; k++) begin
      dly[k] <= dly[k-1];
    end
  end

  always_comb begin
    o0[0] = in0.origin_x;
    o0[1] = in0.origin_y;
    o0[2] = in0.origin_z;
    oa[0] = dly[lbi_pkg::DIV_LAT-1].origin_x;
    oa[1] = dly[lbi_pkg::DIV_LAT-1].origin_y;
    oa[2] = dly[lbi_pkg::DIV_LAT-1].origin_z;
    da[0] = dly[lbi_pkg::DIV_LAT-1].dir_x;
    da[1] = dly[lbi_pkg::DIV_LAT-1].dir_y;
    da[2] = dly[lbi_pkg::DIV_LAT-1].dir_z;
  end

  // one divider and one face test per box face
  for (genvar gf = 0; gf < lbi_pkg::NUM_FACES; gf++) begin : g_face
    localparam int AX = gf / 2;
    localparam int SD = gf % 2;
    localparam int AU = (AX == 0) ? 1 : 0;
    localparam int AV = (AX == 2) ? 1 : 2;

    logic signed [32:0] c_w;
    lbi_pkg::q_t        t_w;
    logic               hit_w;
    lbi_pkg::q_t        pu_w, pv_w, pw_w;
    lbi_pkg::q_t        corner_w;

    assign corner_w = (SD != 0) ? box_hi[AX] : box_lo[AX];
    assign c_w = 33'(((SD != 0) ? box_hi[AX] : box_lo[AX])) - 33'(o0[AX]);

    lbi_div_lane u_div (
      .clk  (clk),
      .num  (c_w),
      .den  (AX == 0 ? in0.dir_x : (AX == 1 ? in0.dir_y : in0.dir_z)),
      .quot (t_w)
    );

    lbi_face u_face (
      .clk    (clk),
      .t      (t_w),
      .dnz    (da[AX] != '0),
      .d_u    (da[AU]),
      .d_v    (da[AV]),
      .o_u    (oa[AU]),
      .o_v    (oa[AV]),
      .lo_u   (box_lo[AU]),
      .hi_u   (box_hi[AU]),
      .lo_v   (box_lo[AV]),
      .hi_v   (box_hi[AV]),
      .corner (corner_w),
      .hit    (hit_w),
      .p_u    (pu_w),
      .p_v    (pv_w),
      .p_w    (pw_w)
    );

    // place the face point back on x, y, z
    always_comb begin
      pts[gf].hit = hit_w;
      if (AX == 0) begin
        pts[gf].x = pw_w;
        pts[gf].y = pu_w;
        pts[gf].z = pv_w;
      end else if (AX == 1) begin
        pts[gf].x = pu_w;
        pts[gf].y = pw_w;
        pts[gf].z = pv_w;
      end else begin
        pts[gf].x = pu_w;
        pts[gf].y = pv_w;
        pts[gf].z = pw_w;
      end
    end
  end

  lbi_seg u_seg (
    .clk    (clk),
    .pts    (pts),
    .result (result)
  );

  // every result traces back to an item taken a fixed depth earlier
  `LBI_ASSERT_IMP(a_done_latency, clk, rst, done, $past(start, lbi_pkg::PIPE_LAT))
  // a miss carries an all-zero segment
  `LBI_ASSERT_IMP(a_miss_zero, clk, rst, done && !result.hit,
    result.seg_start_x == '0 && result.seg_start_y == '0 && result.seg_start_z == '0 &&
    result.seg_end_x == '0 && result.seg_end_y == '0 && result.seg_end_z == '0)
  // a hit's start x and end z lie in the box wherever that axis range is not empty
  `LBI_ASSERT_NEVER(a_start_in_box, clk, rst, done && result.hit &&
    ((box_lo[0] <= box_hi[0] &&
      (result.seg_start_x < box_lo[0] || result.seg_start_x > box_hi[0])) ||
     (box_lo[2] <= box_hi[2] &&
      (result.seg_end_z < box_lo[2] || result.seg_end_z > box_hi[2]))))

endmodule
`default_nettype wire

// ===== sim/line_box_intersection_core_tb.sv =====
// ----------------------------------------------------------------------------
// Line/box intersection core testbench
// Programs several boxes over the register port and sends directed and
// random lines through the core. Each result is checked, field by field,
// against a segment predicted in the testbench from the line and the box.
// ----------------------------------------------------------------------------
`default_nettype none
module line_box_intersection_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lbi_pkg::*;

  localparam longint ONE        = 65536;
  localparam longint I32_MAX    = 64'sd2147483647;
  localparam longint I32_MIN    = -64'sd2147483648;
  localparam int     CYCLE_CAP  = 300000;
  localparam int     RAND_LINES = 450;

  // expected segments and the box copy used to compute them
  class segment_scoreboard;
    longint box_lo[3];
    longint box_hi[3];
    seg_t   pending_segs[$];
    int     errors;
    int     hits_seen;
    int     results_seen;

    function new();
      foreach (box_lo[k]) begin
        box_lo[k] = 0;
        box_hi[k] = 0;
      end
      errors       = 0;
      hits_seen    = 0;
      results_seen = 0;
    endfunction

    function void set_reg(reg_idx_t r, q_t v);
      case (r)
        REG_MIN_X: box_lo[0] = v;
        REG_MIN_Y: box_lo[1] = v;
        REG_MIN_Z: box_lo[2] = v;
        REG_MAX_X: box_hi[0] = v;
        REG_MAX_Y: box_hi[1] = v;
        REG_MAX_Z: box_hi[2] = v;
        default: ;
      endcase
    endfunction

    function logic [65:0] dist_sq(longint a[3], longint b[3]);
      logic [65:0] acc;
      logic [65:0] m;
      longint df;
      acc = '0;
      for (int k = 0; k < 3; k++) begin
        df  = a[k] - b[k];
        m   = (df < 0) ? -df : df;
        acc = acc + m * m;
      end
      return acc;
    endfunction

    function seg_t segment_of(line_t ln);
      longint o[3], d[3], fc[3], lc[3], s[3], e[3], p[3];
      longint c, t, off;
      bit     ok;
      int     n;
      seg_t   r;
      o[0] = ln.origin_x; o[1] = ln.origin_y; o[2] = ln.origin_z;
      d[0] = ln.dir_x;    d[1] = ln.dir_y;    d[2] = ln.dir_z;
      n = 0;
      for (int k = 0; k < 3; k++) begin
        fc[k] = box_lo[k] - o[k];
        lc[k] = box_hi[k] - o[k];
        s[k]  = 0;
        e[k]  = 0;
        p[k]  = 0;
      end
      // scan the six face planes
      for (int a = 0; a < 3; a++) begin
        if (d[a] != 0) begin
          for (int side = 0; side < 2; side++) begin
            c = side ? lc[a] : fc[a];
            t = (c * ONE) / d[a];
            if (t > I32_MAX) t = I32_MAX;
            if (t < I32_MIN) t = I32_MIN;
            ok = 1;
            for (int b = 0; b < 3; b++) begin
              if (b != a) begin
                off = (t * d[b]) / ONE;
                if (off < fc[b] || off > lc[b]) ok = 0;
                p[b] = o[b] + off;
              end
            end
            p[a] = side ? box_hi[a] : box_lo[a];
            if (ok) begin
              if (n == 0) s = p;
              else if (n == 1 || dist_sq(s, e) < dist_sq(s, p)) e = p;
              n++;
            end
          end
        end
      end
      r = '0;
      if (n >= 2) begin
        r.hit = 1'b1;
        r.seg_start_x = s[0][31:0]; r.seg_start_y = s[1][31:0];
        r.seg_start_z = s[2][31:0];
        r.seg_end_x = e[0][31:0]; r.seg_end_y = e[1][31:0]; r.seg_end_z = e[2][31:0];
      end
      return r;
    endfunction

    function void note_line(line_t ln);
      pending_segs.push_back(segment_of(ln));
    endfunction

    function void field_check(string name, longint want, longint got);
      if (want != got) begin
        errors++;
        $display("%0t mismatch %s: expected %0d actual %0d", $realtime, name, want, got);
      end
    endfunction

    function void check_segment(seg_t got);
      seg_t want;
      if (pending_segs.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual %h", $realtime, got);
        return;
      end
      want = pending_segs.pop_front();
      results_seen++;
      if (want.hit) hits_seen++;
      field_check("hit", want.hit, got.hit);
      field_check("seg_start_x", want.seg_start_x, got.seg_start_x);
      field_check("seg_start_y", want.seg_start_y, got.seg_start_y);
      field_check("seg_start_z", want.seg_start_z, got.seg_start_z);
      field_check("seg_end_x", want.seg_end_x, got.seg_end_x);
      field_check("seg_end_y", want.seg_end_y, got.seg_end_y);
      field_check("seg_end_z", want.seg_end_z, got.seg_end_z);
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  line_t               item;
  logic                done;
  seg_t                result;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  segment_scoreboard sb = new();
  int  cycles;
  int  lines_sent;
  int  quiet_lo;
  int  quiet_hi;

  line_box_intersection_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // take each result in the middle of its cycle
  always @(negedge clk) begin
    if (!rst && done) sb.check_segment(result);
  end

  // one register write: setup then access, then return to idle
  task automatic write_reg(reg_idx_t r, q_t v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(r) << 2;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(r, v);
    @(posedge clk);
  endtask

  task automatic set_box(longint lx, longint ly, longint lz,
                         longint hx, longint hy, longint hz);
    write_reg(REG_MIN_X, lx[31:0]);
    write_reg(REG_MIN_Y, ly[31:0]);
    write_reg(REG_MIN_Z, lz[31:0]);
    write_reg(REG_MAX_X, hx[31:0]);
    write_reg(REG_MAX_Y, hy[31:0]);
    write_reg(REG_MAX_Z, hz[31:0]);
    @(posedge clk);
  endtask

  // hold start until the core takes the item, then maybe idle
  task automatic send_line(line_t ln);
    logic was_busy;
    start <= 1'b1;
    item  <= ln;
    do begin
      @(negedge clk);
      was_busy = busy;
      @(posedge clk);
    end while (was_busy);
    sb.note_line(ln);
    lines_sent++;
    if (!(lines_sent >= quiet_lo && lines_sent < quiet_hi)) begin
      while ($urandom_range(99) < 28) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  // drop start and let every expected result come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_segs.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  function automatic line_t mk(longint ox, longint oy, longint oz,
                               longint dx, longint dy, longint dz);
    line_t ln;
    ln.origin_x = ox[31:0]; ln.origin_y = oy[31:0]; ln.origin_z = oz[31:0];
    ln.dir_x = dx[31:0]; ln.dir_y = dy[31:0]; ln.dir_z = dz[31:0];
    return ln;
  endfunction

  function automatic longint rnd_between(longint a, longint b);
    longint unsigned span;
    longint unsigned r;
    longint tmp;
    if (b < a) begin
      tmp = a; a = b; b = tmp;
    end
    span = b - a + 1;
    r = {$urandom, $urandom};
    return a + longint'(r % span);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > I32_MAX) return I32_MAX;
    if (v < I32_MIN) return I32_MIN;
    return v;
  endfunction

  // mostly lines aimed through the box, some pure noise
  function automatic line_t random_line();
    longint p[3], q[3], d[3], w;
    int     pick;
    line_t  ln;
    if ($urandom_range(99) < 15) begin
      ln = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      return ln;
    end
    for (int k = 0; k < 3; k++) begin
      w    = sb.box_hi[k] - sb.box_lo[k];
      if (w < 0) w = -w;
      p[k] = clamp32(rnd_between(sb.box_lo[k] - w / 2 - ONE, sb.box_hi[k] + w / 2 + ONE));
      q[k] = rnd_between(sb.box_lo[k], sb.box_hi[k]);
      d[k] = clamp32(q[k] - p[k]);
    end
    pick = $urandom_range(9);
    case (pick)
      0: d[$urandom_range(2)] = 0;
      1: begin
        d[0] = 0;
        d[$urandom_range(2, 1)] = 0;
      end
      2: for (int k = 0; k < 3; k++) d[k] = (d[k] < 0) ? -1 : 1;
      3: if ($urandom_range(3) == 0) d = '{0, 0, 0};
      default: ;
    endcase
    return mk(p[0], p[1], p[2], d[0], d[1], d[2]);
  endfunction

  task automatic random_lines(int n, bit pause_midway);
    for (int i = 0; i < n; i++) begin
      if (pause_midway && i == n / 2) drain();
      send_line(random_line());
    end
  endtask

  initial begin
    rst        <= 1'b1;
    start      <= 1'b0;
    item       <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    cycles     = 0;
    lines_sent = 0;
    quiet_lo   = 190;
    quiet_hi   = 300;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // cube from -1.0 to 1.0 on each axis around the origin
    set_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
    send_line(mk(0, 0, 0, 0, 0, 0));                       // zero direction
    send_line(mk(-3 * ONE, 0, 0, ONE, 0, 0));              // axis-parallel
    send_line(mk(0, -3 * ONE, 0, ONE, ONE, 0));            // face-parallel
    send_line(mk(0, 0, 0, ONE, 2 * ONE, 3 * ONE));         // general
    send_line(mk(0, 0, 0, ONE, ONE, ONE));                 // through corners
    send_line(mk(5 * ONE, 5 * ONE, 5 * ONE, ONE, 0, 0));   // miss
    send_line(mk(0, ONE, 0, ONE, 0, 0));                   // along a face
    send_line(mk(2 * ONE, 0, 0, ONE, ONE, 0));             // touch one edge
    send_line(mk(0, 0, 0, 1, 0, 0));                       // saturated t
    send_line(mk(0, 0, 0, 1, 1, 3));
    send_line(mk(0, 0, 0, -ONE, -2 * ONE, 0));
    send_line(mk(I32_MIN, I32_MIN, I32_MIN, I32_MAX, I32_MAX, I32_MAX));
    send_line(mk(I32_MAX, I32_MAX, I32_MAX, I32_MIN, I32_MIN, I32_MIN));
    send_line(mk(0, 0, 0, I32_MIN, 0, 0));
    send_line(mk(0, 0, 0, -1, -1, -1));
    send_line(mk(ONE / 2, ONE / 2, 0, 0, 0, ONE));
    random_lines(60, 1'b0);
    drain();

    // widest box
    set_box(I32_MIN, I32_MIN, I32_MIN, I32_MAX, I32_MAX, I32_MAX);
    send_line(mk(0, 0, 0, ONE, 0, 0));
    send_line(mk(I32_MIN, I32_MAX, 0, I32_MAX, I32_MIN, 1));
    random_lines(100, 1'b1);
    drain();

    // small random box, no idling in part of it
    set_box(-$urandom_range(8 * ONE), -$urandom_range(8 * ONE), -$urandom_range(8 * ONE),
            $urandom_range(8 * ONE), $urandom_range(8 * ONE), $urandom_range(8 * ONE));
    random_lines(140, 1'b0);
    drain();

    // inverted on one axis, then the degenerate point box
    set_box(ONE, -ONE, -ONE, -ONE, ONE, ONE);
    random_lines(50, 1'b0);
    drain();
    set_box(0, 0, 0, 0, 0, 0);
    send_line(mk(-ONE, -ONE, -ONE, ONE, ONE, ONE));
    random_lines(50, 1'b0);
    drain();

    // far off-center box
    set_box(I32_MAX - 4 * ONE, I32_MIN, 100 * ONE, I32_MAX, I32_MIN + 4 * ONE, 104 * ONE);
    random_lines(50, 1'b0);
    drain();

    $display("Sent %0d lines over six boxes (unit, widest, random, inverted, point, off-center).",
             lines_sent);
    $display("Checked %0d segments, %0d of them hits.", sb.results_seen, sb.hits_seen);
    if (sb.errors == 0 && sb.pending_segs.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
